### design/mbd_pkg.sv
`timescale 1ns / 1ps

package mbd_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned StepW   = 32;
  localparam int unsigned ColsW   = 11;
  localparam int unsigned FracW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned MaxColsDef = 1024;

  // number of radix-2 quotient bits produced after the overflow check
  localparam int unsigned DivSteps = 32;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam logic [DataW-1:0] SlopeMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0] SlopeMin = {1'b1, {(DataW-1){1'b0}}};

  localparam logic [StepW-1:0] StepReset = StepW'(32'h0001_0000);
  localparam logic [ColsW-1:0] ColsReset = ColsW'(1024);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE     = 2'd0,
    CFG_ROW_STEP = 2'd1,
    CFG_COL_STEP = 2'd2,
    CFG_COLS     = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_PREP,
    S_DIV,
    S_DONE
  } state_e;

  typedef struct packed {
    logic signed [DataW-1:0] sample;
    logic                    start_req;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0] slope;
    logic                    saturated;
  } out_t;

endpackage

### design/matrix_backward_difference.sv
`timescale 1ns / 1ps
// Backward difference over a matrix streamed in raster order, Q16.16 in and out.
// Input channel: in_valid_i / in_stall_o with one element and a start flag per
// transaction; start_req marks the first element of a matrix.
// Output channel: out_valid_o / out_stall_i, one slope and saturation flag per
// input transaction, in input order.
// Configuration: cfg_we_i writes cfg_data_i to the register picked by cfg_idx_i
// (mode, row step, column step, columns in use); write only while idle.
// Flow: one element at a time; the input stays stalled from the accepting edge
// until the result has been handed to the output register. The 32-step radix-2
// divider runs only when needed: elements on the first row or column, equal
// samples and overflow go straight from the prepare state to the done state.
// The output register decouples the sides: a new element is accepted while a
// result waits; if the receiver stalls, the next result waits in the done state
// and the input is stalled until it moves.
// Reset restores the register defaults (mode 1, steps 1.0, 1024 columns), clears
// the column counter and marks the first row. The row store holds no reset value.
module matrix_backward_difference #(
  parameter int unsigned MaxCols = mbd_pkg::MaxColsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  mbd_pkg::in_t                       in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output mbd_pkg::out_t                      out_data_o,
  input  logic                               cfg_we_i,
  input  logic [mbd_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [mbd_pkg::StepW-1:0]          cfg_data_i
);
  import mbd_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxCols);
  localparam int unsigned CntW = (IdxW + 1 > ColsW) ? IdxW + 1 : ColsW;

  // configuration
  logic             mode_q;
  logic [StepW-1:0] row_step_q, col_step_q;
  logic [ColsW-1:0] cols_q;

  // control
  state_e             state_q, state_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;
  logic [IdxW-1:0]    col_q, col_d;
  logic               first_q, first_d;
  logic               out_valid_q;

  // datapath
  logic [DataW-1:0]   prev_q;
  logic [DataW-1:0]   mem_rd_q;
  logic [DataW-1:0]   sample_q, left_q;
  logic [StepW-1:0]   step_q;
  logic               use_left_q;
  logic               zero_q;
  logic [DataW:0]     diff_q;
  logic [StepW-1:0]   rem_q;
  logic [DataW-1:0]   dvd_q;
  logic               neg_q, ovf_q;
  out_t               out_q, out_d;

  logic [DataW-1:0]   row_mem [MaxCols];

  logic               in_fire, out_free;
  logic [IdxW-1:0]    eff_col;
  logic               eff_first;
  logic [CntW-1:0]    cols_eff, nxt_col;
  logic [DataW-1:0]   other;
  logic [DataW:0]     mag;
  logic [StepW+1:0]   trial;
  logic               qbit;
  logic               sat;
  logic [DataW-1:0]   q_signed;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // column bookkeeping at the accepting edge
  always_comb begin
    eff_col   = in_data_i.start_req ? '0 : col_q;
    eff_first = in_data_i.start_req ? 1'b1 : first_q;
    cols_eff  = CntW'(cols_q);
    if (cols_eff == '0) begin
      cols_eff = CntW'(1);
    end else if (cols_eff > CntW'(MaxCols)) begin
      cols_eff = CntW'(MaxCols);
    end
    nxt_col = CntW'(eff_col) + CntW'(1);
    if (nxt_col >= cols_eff) begin
      col_d   = '0;
      first_d = 1'b0;
    end else begin
      col_d   = nxt_col[IdxW-1:0];
      first_d = eff_first;
    end
  end

  always_comb begin
    other = use_left_q ? left_q : mem_rd_q;
    mag   = diff_q[DataW] ? (~diff_q + (DataW+1)'(1)) : diff_q;
    trial = {1'b0, rem_q, dvd_q[DataW-1]} - {2'b00, step_q};
    qbit  = !trial[StepW+1];
    sat   = ovf_q || (dvd_q[DataW-1] && (!neg_q || (dvd_q[DataW-2:0] != '0)));
    q_signed = neg_q ? (~dvd_q + DataW'(1)) : dvd_q;
    if (zero_q) begin
      out_d.slope     = '0;
      out_d.saturated = 1'b0;
    end else if (sat) begin
      out_d.slope     = neg_q ? SlopeMin : SlopeMax;
      out_d.saturated = 1'b1;
    end else begin
      out_d.slope     = q_signed;
      out_d.saturated = 1'b0;
    end
  end

  always_comb begin
    state_d   = state_q;
    div_cnt_d = div_cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_LOAD;
      end
      S_LOAD: state_d = S_PREP;
      S_PREP: begin
        // first row/column, equal samples and overflow need no divide steps
        if (zero_q || mag == '0 || ({15'b0, mag[DataW:FracW]} >= step_q)) begin
          state_d = S_DONE;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        div_cnt_d = div_cnt_q + DivCntW'(1);
        if (div_cnt_q == DivCntW'(DivSteps - 1)) begin
          div_cnt_d = '0;
          state_d   = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      div_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      div_cnt_q <= div_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b1;
      row_step_q <= StepReset;
      col_step_q <= StepReset;
      cols_q     <= ColsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE:     mode_q     <= cfg_data_i[0];
        CFG_ROW_STEP: row_step_q <= cfg_data_i;
        CFG_COL_STEP: col_step_q <= cfg_data_i;
        CFG_COLS:     cols_q     <= cfg_data_i[ColsW-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        col_q   <= col_d;
        first_q <= first_d;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // row store: old entry read and new one written in the accepting transaction
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mem_rd_q         <= row_mem[eff_col];
      row_mem[eff_col] <= in_data_i.sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      prev_q     <= in_data_i.sample;
      left_q     <= prev_q;
      sample_q   <= in_data_i.sample;
      use_left_q <= mode_q;
      step_q     <= mode_q ? col_step_q : row_step_q;
      zero_q     <= mode_q ? (eff_col == '0) : eff_first;
    end
    unique case (state_q)
      S_LOAD: diff_q <= {sample_q[DataW-1], sample_q} - {other[DataW-1], other};
      S_PREP: begin
        neg_q  <= diff_q[DataW];
        ovf_q  <= ({15'b0, mag[DataW:FracW]} >= step_q);
        zero_q <= zero_q || (mag == '0);
        rem_q  <= StepW'(mag[DataW:FracW]);
        dvd_q  <= {mag[FracW-1:0], {(DataW-FracW){1'b0}}};
      end
      S_DIV: begin
        // dividend bits shift out at the top, quotient bits shift in at the bottom
        rem_q <= qbit ? trial[StepW-1:0] : {rem_q[StepW-2:0], dvd_q[DataW-1]};
        dvd_q <= {dvd_q[DataW-2:0], qbit};
      end
      S_DONE: begin
        if (out_free) out_q <= out_d;
      end
      default: ;
    endcase
  end

  ap_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_DIV) |-> (div_cnt_q == '0))
    else $error("divide counter running outside divide state");

  ap_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_stall_o)
    else $error("input not stalled after a transaction");

  ap_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.saturated) |->
      (out_data_o.slope == SlopeMax || out_data_o.slope == SlopeMin))
    else $error("saturated result not at a limit");

  ap_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CntW'(col_q) < CntW'(MaxCols)))
    else $error("column index out of range");

endmodule

### bench/matrix_backward_difference_tb.sv
`timescale 1ns / 1ps

module matrix_backward_difference_tb;
  import mbd_pkg::*;

  localparam int unsigned RandPhases = 10;
  localparam int unsigned PhaseElems = 75;

  typedef enum logic {ROW_CFG, ROW_ELEM} plan_kind_e;

  typedef struct {
    plan_kind_e  kind;
    cfg_idx_e    idx;
    logic [31:0] value;
    logic        start;
    bit          known;
    out_t        want;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [StepW-1:0] cfg_data_i = '0;

  matrix_backward_difference dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the block: registers, row store, left neighbor, position
  bit          sh_mode = 1'b1;
  logic [31:0] sh_row_step = 32'h0001_0000;
  logic [31:0] sh_col_step = 32'h0001_0000;
  logic [10:0] sh_cols = 11'd1024;
  logic [31:0] row_mem [MaxColsDef];
  bit          row_seen [MaxColsDef];
  logic [31:0] left_sample = '0;
  bit          left_seen = 1'b0;
  int unsigned col_pos = 0;
  bit          top_row = 1'b1;

  out_t        slope_q [$];
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_kind = 0;
  plan_row_t   plan_q [$];

  // (diff << 16) / step, truncated toward zero and clipped to 32 bits
  function automatic out_t calc_slope(longint diff, logic [31:0] step);
    longint unsigned mag;
    longint unsigned lim;
    longint unsigned q;
    out_t r;
    r = '0;
    if (diff != 0) begin
      mag = (diff < 0) ? longint'(-diff) : longint'(diff);
      lim = (diff < 0) ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (step == '0) begin
        q = lim + 1;
      end else begin
        q = (mag << 16) / {32'h0, step};
      end
      if (q > lim) begin
        q = lim;
        r.saturated = 1'b1;
      end
      r.slope = (diff < 0) ? -q[31:0] : q[31:0];
    end
    return r;
  endfunction

  function automatic plan_row_t cfg_row(cfg_idx_e idx, logic [31:0] d);
    plan_row_t p;
    p = '{kind: ROW_CFG, idx: idx, value: d, start: 1'b0, known: 1'b0, want: '0};
    return p;
  endfunction

  function automatic plan_row_t elem_row(logic [31:0] s, logic st);
    plan_row_t p;
    p = '{kind: ROW_ELEM, idx: CFG_MODE, value: s, start: st, known: 1'b0, want: '0};
    return p;
  endfunction

  function automatic plan_row_t known_row(logic [31:0] s, logic st, logic [31:0] sl, logic sat);
    plan_row_t p;
    p = '{kind: ROW_ELEM, idx: CFG_MODE, value: s, start: st, known: 1'b1,
          want: '{slope: sl, saturated: sat}};
    return p;
  endfunction

  task automatic plan_add(plan_row_t p);
    plan_q.insert(plan_q.size(), p);
  endtask

  function automatic logic [31:0] pick_sample();
    logic [31:0] s;
    case ($urandom_range(0, 9))
      0: s = 32'h7FFF_FFFF;
      1: s = 32'h8000_0000;
      2: s = 32'h0;
      3, 4, 5: s = $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
      default: s = $urandom;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] pick_step();
    logic [31:0] s;
    case ($urandom_range(0, 9))
      0: s = 32'h0;
      1: s = 32'h1;
      2: s = 32'hFFFF_FFFF;
      3, 4: s = 32'h0001_0000;
      5, 6: s = $urandom_range(1, 32'h4_0000);
      default: s = $urandom;
    endcase
    return s;
  endfunction

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (slope_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [31:0] d);
    case (idx)
      CFG_MODE:     sh_mode = d[0];
      CFG_ROW_STEP: sh_row_step = d;
      CFG_COL_STEP: sh_col_step = d;
      CFG_COLS:     sh_cols = d[10:0];
      default: ;
    endcase
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // predict one element, queue its result, then hand it over
  task automatic send_elem(logic [31:0] s, logic st, bit use_known, out_t known);
    int unsigned cols_eff;
    int unsigned c;
    int unsigned gap;
    out_t res;
    cols_eff = (sh_cols == 0) ? 1 : ((sh_cols > MaxColsDef) ? MaxColsDef : sh_cols);
    c = (col_pos >= MaxColsDef) ? MaxColsDef - 1 : col_pos;
    // never make the block read a row entry or left sample it has not stored
    if (!st && ((!sh_mode && !top_row && !row_seen[c]) || (sh_mode && c != 0 && !left_seen)))
      st = 1'b1;
    if (st) begin
      col_pos = 0;
      top_row = 1'b1;
      c = 0;
    end
    res = '0;
    if (!sh_mode && !top_row) begin
      res = calc_slope(longint'($signed(s)) - longint'($signed(row_mem[c])), sh_row_step);
    end else if (sh_mode && c != 0) begin
      res = calc_slope(longint'($signed(s)) - longint'($signed(left_sample)), sh_col_step);
    end
    row_mem[c] = s;
    row_seen[c] = 1'b1;
    left_sample = s;
    left_seen = 1'b1;
    c++;
    if (c >= cols_eff) begin
      c = 0;
      top_row = 1'b0;
    end
    col_pos = c;
    slope_q.insert(slope_q.size(), use_known ? known : res);

    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 15);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{sample: s, start_req: st};
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
  endtask

  // result side: check each transaction, then pick the next stall pattern step
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (slope_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: slope %h sat %b", out_data_o.slope,
                   out_data_o.saturated);
      end else begin
        want = slope_q.pop_front();
        if (out_data_o.slope !== want.slope || out_data_o.saturated !== want.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected slope %h sat %b, got slope %h sat %b",
                     want.slope, want.saturated, out_data_o.slope, out_data_o.saturated);
        end
      end
    end
    if (stall_left == 0) begin
      stall_kind = $urandom_range(0, 2);
      stall_left = $urandom_range(1, 40);
    end
    stall_left--;
    case (stall_kind)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= 1'b1;
      default: out_stall_i <= $urandom_range(0, 1);
    endcase
  end

  initial begin
    int unsigned sent;
    int unsigned n;
    int unsigned cols_eff;
    logic [31:0] r;
    logic st;

    // row length 4, differences along rows with unit step
    plan_add(cfg_row(CFG_COLS, 32'd4));
    plan_add(known_row(32'h7FFF_FFFF, 1'b1, 32'h0, 1'b0));
    plan_add(known_row(32'h8000_0000, 1'b0, 32'h8000_0000, 1'b1));
    plan_add(known_row(32'h7FFF_FFFF, 1'b0, 32'h7FFF_FFFF, 1'b1));
    plan_add(known_row(32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0));
    plan_add(known_row(32'd5, 1'b0, 32'h0, 1'b0));
    plan_add(elem_row(32'h0003_0000, 1'b0));
    // down columns, step 2.0
    plan_add(cfg_row(CFG_MODE, 32'd0));
    plan_add(cfg_row(CFG_ROW_STEP, 32'h0002_0000));
    plan_add(known_row(32'h0001_0000, 1'b1, 32'h0, 1'b0));
    plan_add(known_row(32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0));
    plan_add(known_row(32'h1234_5678, 1'b0, 32'h0, 1'b0));
    plan_add(known_row(32'h8000_0000, 1'b0, 32'h0, 1'b0));
    plan_add(known_row(32'h0003_0000, 1'b0, 32'h0001_0000, 1'b0));
    plan_add(known_row(32'h7FFF_FFFF, 1'b0, 32'h4000_0000, 1'b0));
    plan_add(elem_row(32'h0000_1234, 1'b0));
    // one column per row, zero step
    plan_add(cfg_row(CFG_COLS, 32'd1));
    plan_add(cfg_row(CFG_ROW_STEP, 32'h0));
    plan_add(known_row(32'd100, 1'b1, 32'h0, 1'b0));
    plan_add(known_row(32'd100, 1'b0, 32'h0, 1'b0));
    plan_add(known_row(32'd200, 1'b0, 32'h7FFF_FFFF, 1'b1));
    plan_add(known_row(32'd50, 1'b0, 32'h8000_0000, 1'b1));
    plan_add(cfg_row(CFG_ROW_STEP, 32'hFFFF_FFFF));
    plan_add(elem_row(32'h7FFF_FFFF, 1'b0));
    plan_add(elem_row(32'h8000_0000, 1'b0));
    // row length zero acts as one, changed without a new matrix
    plan_add(cfg_row(CFG_COLS, 32'd0));
    plan_add(cfg_row(CFG_MODE, 32'd1));
    plan_add(known_row(32'd7, 1'b0, 32'h0, 1'b0));
    // oversize row length, smallest step
    plan_add(cfg_row(CFG_COLS, 32'd2047));
    plan_add(cfg_row(CFG_COL_STEP, 32'd1));
    plan_add(known_row(32'h0, 1'b1, 32'h0, 1'b0));
    plan_add(known_row(32'h1, 1'b0, 32'h0001_0000, 1'b0));
    plan_add(elem_row(32'h0000_8000, 1'b0));
    plan_add(known_row(32'h0001_0000, 1'b0, 32'h7FFF_FFFF, 1'b1));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan_q[i]) begin
      if (plan_q[i].kind == ROW_CFG) begin
        wait_idle();
        cfg_write(plan_q[i].idx, plan_q[i].value);
      end else begin
        send_elem(plan_q[i].value, plan_q[i].start, plan_q[i].known, plan_q[i].want);
      end
    end

    for (int unsigned ph = 0; ph < RandPhases; ph++) begin
      wait_idle();
      if ($urandom_range(0, 3) != 0) begin
        r = $urandom;
        cfg_write(CFG_MODE, {r[31:1], 1'($urandom_range(0, 1))});
      end
      if ($urandom_range(0, 3) != 0) cfg_write(CFG_ROW_STEP, pick_step());
      if ($urandom_range(0, 3) != 0) cfg_write(CFG_COL_STEP, pick_step());
      if ($urandom_range(0, 3) != 0) begin
        r = $urandom;
        case ($urandom_range(0, 19))
          0: r[10:0] = 11'd0;
          1: r[10:0] = 11'($urandom_range(1025, 2047));
          2: r[10:0] = 11'd1024;
          3, 4, 5: r[10:0] = 11'($urandom_range(9, 40));
          default: r[10:0] = 11'($urandom_range(1, 8));
        endcase
        cfg_write(CFG_COLS, r);
      end

      sent = 0;
      while (sent < PhaseElems) begin
        if ($urandom_range(0, 9) < 8) begin
          // well-formed matrix, now and then with a misplaced start flag
          cols_eff = (sh_cols == 0) ? 1 : ((sh_cols > MaxColsDef) ? MaxColsDef : sh_cols);
          n = $urandom_range(1, 4) * cols_eff;
          for (int unsigned k = 0; k < n && sent < PhaseElems; k++) begin
            st = (k == 0);
            if ($urandom_range(0, 39) == 0) st = ~st;
            send_elem(pick_sample(), st, 1'b0, '0);
            sent++;
          end
        end else begin
          n = $urandom_range(1, 6);
          for (int unsigned k = 0; k < n && sent < PhaseElems; k++) begin
            send_elem(pick_sample(), $urandom_range(0, 3) == 0, 1'b0, '0);
            sent++;
          end
        end
      end
    end

    in_valid_i <= 1'b0;
    while (slope_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** matrix_backward_difference: PASSED **");
    end else begin
      $display("** matrix_backward_difference: FAILED **");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("** matrix_backward_difference: FAILED **");
    $finish;
  end

endmodule
